/* rtl/nmd_pkg.sv */
// Shared types and constants for the nearest midpoint distance block.
package nmd_pkg;

   localparam int COORD_W  = 31;
   localparam int REL_W    = 16;
   localparam int MODE_W   = 2;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd16;

   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

   localparam logic DIST_ABS = 1'b0;
   localparam logic DIST_REL = 1'b1;

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SRCH_RD  = 9'b000000010,
      ST_SRCH_CMP = 9'b000000100,
      ST_GET_L    = 9'b000001000,
      ST_GET_R    = 9'b000010000,
      ST_CALC     = 9'b000100000,
      ST_DIV      = 9'b001000000,
      ST_SHIFT    = 9'b010000000,
      ST_EMIT     = 9'b100000000
   } state_type;

endpackage

/* rtl/nearest_midpoint_distance.sv */
// Top level of the nearest midpoint distance block: sorted store, search, serial divide.
// Search: binary search, one read of the shared store port per step. Clear: empties the store.
// Insert: the search, entries at or past the slot shift up one, then the midpoint is written.
// Query: the search, two flank reads, one compare, a serial divide in relative mode and a load
// of the result register once it is free; a relative query at an end or at equal flanks gives
// no result. One item at a time; sync active-high reset empties the store, sets absolute mode.
module nearest_midpoint_distance
   import nmd_pkg::*;
#(
   parameter int REF_DEPTH = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [COORD_W-1:0] req_start_req,
   input  logic [COORD_W-1:0] req_stop,
   input  logic [COORD_W-1:0] req_query_id,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_result_id,
   output logic [COORD_W-1:0] rsp_abs_distance,
   output logic [REL_W-1:0]   rsp_rel_distance
);

   localparam int AW = $clog2(REF_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(REF_DEPTH);

   // Sorted midpoint store: one write port and one registered read port.
   logic [COORD_W-1:0] mem [REF_DEPTH];
   logic [AW-1:0]      rd_addr;
   logic [COORD_W-1:0] rd_q;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [COORD_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic               dist_mode_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]      sh_ff, sh_in;
   logic               insert_ff, insert_in;
   logic               rel_ff, rel_in;
   logic [COORD_W-1:0] mid_ff, mid_in, id_ff, id_in;
   logic [COORD_W-1:0] left_ff, left_in;
   logic [COORD_W-1:0] gap_ff, gap_in;
   logic [COORD_W-1:0] absd_ff, absd_in;
   logic [COORD_W:0]   rem_ff, rem_in;
   logic [REL_W-1:0]   quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_id_ff, rsp_id_in, rsp_abs_ff, rsp_abs_in;
   logic [REL_W-1:0]   rsp_rel_ff, rsp_rel_in;

   logic [CW-1:0]      probe;
   logic               go_right;
   logic [COORD_W:0]   req_sum;
   logic [COORD_W-1:0] dl, dr, dmin;
   logic [COORD_W:0]   rem_sh;
   logic               at_low_end, at_high_end;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_sum   = {1'b0, req_start_req} + {1'b0, req_stop};
   assign probe     = lo_ff + ((hi_ff - lo_ff) >> 1);
   // Insert places after equal entries, a query finds the first entry not below it.
   assign go_right  = insert_ff ? (rd_q <= mid_ff) : (rd_q < mid_ff);
   assign at_low_end  = (lo_ff == '0);
   assign at_high_end = (lo_ff == count_ff);
   assign dl   = mid_ff - left_ff;
   assign dr   = rd_q - mid_ff;
   assign dmin = (dl < dr) ? dl : dr;
   assign rem_sh = {rem_ff[COORD_W-1:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      sh_in        = sh_ff;
      insert_in    = insert_ff;
      rel_in       = rel_ff;
      mid_in       = mid_ff;
      id_in        = id_ff;
      left_in      = left_ff;
      gap_in       = gap_ff;
      absd_in      = absd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_id_in    = rsp_id_ff;
      rsp_abs_in   = rsp_abs_ff;
      rsp_rel_in   = rsp_rel_ff;
      rd_addr      = probe[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = sh_ff;
      wr_data      = rd_q;

      case (state_ff)
         ST_IDLE: begin
            mid_in    = req_sum[COORD_W:1];
            id_in     = req_query_id;
            insert_in = (req_mode == MODE_INSERT);
            rel_in    = (dist_mode_ff == DIST_REL);
            lo_in     = '0;
            hi_in     = count_ff;
            if (req_valid) begin
               if (req_mode == MODE_CLEAR) begin
                  count_in = '0;
               end else if (req_mode == MODE_INSERT && count_ff < DEPTH_C) begin
                  state_in = ST_SRCH_RD;
               end else if (req_mode == MODE_QUERY && count_ff != '0) begin
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_SRCH_RD: begin
            // The read of the probe entry is issued here.
            if (lo_ff < hi_ff) begin
               state_in = ST_SRCH_CMP;
            end else if (insert_ff) begin
               sh_in    = count_ff[AW-1:0];
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_GET_L;
            end
         end
         ST_SRCH_CMP: begin
            if (go_right) begin
               lo_in = probe + 1'b1;
            end else begin
               hi_in = probe;
            end
            state_in = ST_SRCH_RD;
         end
         ST_SHIFT: begin
            // Reads entry sh-1 here; the next cycle writes it one place up.
            rd_addr = sh_ff - 1'b1;
            if ({1'b0, sh_ff} > lo_ff) begin
               state_in = ST_GET_R;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = lo_ff[AW-1:0];
               wr_data  = mid_ff;
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_GET_L: begin
            rd_addr  = at_low_end ? '0 : AW'(lo_ff - 1'b1);
            state_in = ST_CALC;
            if (!insert_ff) begin
               state_in = ST_GET_R;
            end
         end
         ST_GET_R: begin
            if (insert_ff) begin
               wr_en    = 1'b1;
               sh_in    = sh_ff - 1'b1;
               state_in = ST_SHIFT;
            end else begin
               left_in  = rd_q;
               rd_addr  = at_high_end ? AW'(count_ff - 1'b1) : lo_ff[AW-1:0];
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            // rd_q holds the right flank, left_ff the left flank.
            rem_in  = {1'b0, dmin};
            gap_in  = rd_q - left_ff;
            step_in = DIV_STEPS;
            quo_in  = '0;
            absd_in = at_low_end ? dr : (at_high_end ? dl : dmin);
            if (!rel_ff) begin
               state_in = ST_EMIT;
            end else if (at_low_end || at_high_end || rd_q == left_ff) begin
               state_in = ST_IDLE;
            end else begin
               absd_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {1'b0, gap_ff}) begin
               rem_in = rem_sh - {1'b0, gap_ff};
               quo_in = {quo_ff[REL_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[REL_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == DIV_CNT_W'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_abs_in   = absd_ff;
               rsp_rel_in   = rel_ff ? quo_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dist_mode_ff <= DIST_ABS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            dist_mode_ff <= csr_wr_data;
         end
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      sh_ff      <= sh_in;
      insert_ff  <= insert_in;
      rel_ff     <= rel_in;
      mid_ff     <= mid_in;
      id_ff      <= id_in;
      left_ff    <= left_in;
      gap_ff     <= gap_in;
      absd_ff    <= absd_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_abs_ff <= rsp_abs_in;
      rsp_rel_ff <= rsp_rel_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_id    = rsp_id_ff;
   assign rsp_abs_distance = rsp_abs_ff;
   assign rsp_rel_distance = rsp_rel_ff;

endmodule

/* rtl/nmd_checker.sv */
// Port-level checker for the nearest midpoint distance block, with its bind.
module nmd_checker
   import nmd_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [MODE_W-1:0]  req_mode,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [COORD_W-1:0] rsp_result_id,
   input logic [COORD_W-1:0] rsp_abs_distance,
   input logic [REL_W-1:0]   rsp_rel_distance
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_id) && $stable(rsp_abs_distance))
      else $error("result changed while stalled");

   a_rel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_rel_distance <= 16'd32768) else $error("relative distance too big");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_abs_distance == '0 || rsp_rel_distance == '0))
      else $error("both distances nonzero");

   a_no_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != MODE_QUERY |=> !$rose(rsp_valid))
      else $error("result after a non-query transfer");

endmodule

bind nearest_midpoint_distance nmd_checker u_nmd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_mode(req_mode),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_result_id(rsp_result_id),
   .rsp_abs_distance(rsp_abs_distance),
   .rsp_rel_distance(rsp_rel_distance)
);
